>>> rtl/kbr_pkg.sv
// Shared types and constants for the 6KRO boot keyboard report builder.
// No dependencies; used by every module of the block by scoped names.
package kbr_pkg;

  localparam int unsigned KeySlots  = 6;
  localparam int unsigned MapBytes  = 32;
  localparam int unsigned IdxW      = $clog2(MapBytes);
  localparam int unsigned FillW     = $clog2(KeySlots + 1);
  localparam logic [7:0]  RolloverCode = 8'h01;

  // request codes carried on tuser
  localparam logic [2:0] REQ_PRESS    = 3'd0;
  localparam logic [2:0] REQ_RELEASE  = 3'd1;
  localparam logic [2:0] REQ_MOD_SET  = 3'd2;
  localparam logic [2:0] REQ_MOD_CLR  = 3'd3;
  localparam logic [2:0] REQ_RESET    = 3'd4;

  typedef logic [KeySlots-1:0][7:0] slots_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] req;
    logic [7:0] usage;
    logic [7:0] mask;
  } event_t;

endpackage

>>> rtl/kbr_keymap.sv
// Pressed-key bitmap, pressed-key count and modifier byte.
// Applies one event per transfer; one byte read port for the scanner. Uses kbr_pkg.
module kbr_keymap (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  kbr_pkg::event_t            event_i,
  input  logic [kbr_pkg::IdxW-1:0]   rd_idx_i,
  output logic [7:0]                 rd_byte_o,
  output logic [8:0]                 count_o,
  output logic [7:0]                 mods_o
);

  logic [kbr_pkg::MapBytes-1:0][7:0] map_q, map_d;
  logic [8:0]                        count_q, count_d;
  logic [7:0]                        mods_q, mods_d;
  logic [kbr_pkg::IdxW-1:0]          ev_idx;
  logic [7:0]                        ev_byte, ev_bit;

  assign ev_idx  = event_i.usage[7:3];
  assign ev_byte = map_q[ev_idx];
  assign ev_bit  = 8'h01 << event_i.usage[2:0];

  always_comb begin
    map_d   = map_q;
    count_d = count_q;
    mods_d  = mods_q;
    if (event_i.valid) begin
      unique case (event_i.req)
        kbr_pkg::REQ_PRESS: begin
          if ((ev_byte & ev_bit) == 8'h00) begin
            map_d[ev_idx] = ev_byte | ev_bit;
            count_d       = count_q + 9'd1;
          end
        end
        kbr_pkg::REQ_RELEASE: begin
          if ((ev_byte & ev_bit) != 8'h00) begin
            map_d[ev_idx] = ev_byte & ~ev_bit;
            count_d       = count_q - 9'd1;
          end
        end
        kbr_pkg::REQ_MOD_SET: mods_d = mods_q | event_i.mask;
        kbr_pkg::REQ_MOD_CLR: mods_d = mods_q & ~event_i.mask;
        kbr_pkg::REQ_RESET: begin
          map_d   = '0;
          count_d = '0;
          mods_d  = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q   <= '0;
      count_q <= '0;
      mods_q  <= '0;
    end else begin
      map_q   <= map_d;
      count_q <= count_d;
      mods_q  <= mods_d;
    end
  end

  assign rd_byte_o = map_q[rd_idx_i];
  assign count_o   = count_q;
  assign mods_o    = mods_q;

  // count tracks the number of set map bits
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == 9'($countones(map_q)))
    else $error("pressed count out of step with key map");

endmodule

>>> rtl/kbr_scanner.sv
// Scan unit: takes one map byte per cycle while step_i is high and fills
// the key slots in ascending usage order. Uses kbr_pkg.
module kbr_scanner (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       clear_i,
  input  logic                       step_i,
  input  logic [kbr_pkg::IdxW-1:0]   base_i,
  input  logic [7:0]                 byte_i,
  output kbr_pkg::slots_t            slots_o,
  output logic                       full_o
);

  kbr_pkg::slots_t                   slots_q, slots_d;
  logic [kbr_pkg::FillW-1:0]         fill_q, fill_d;

  // up to eight set bits per byte, placed one after another
  always_comb begin
    slots_d = slots_q;
    fill_d  = fill_q;
    if (clear_i) begin
      slots_d = '0;
      fill_d  = '0;
    end else if (step_i) begin
      for (int b = 0; b < 8; b++) begin
        if (byte_i[b] && (fill_d < kbr_pkg::FillW'(kbr_pkg::KeySlots))) begin
          slots_d[fill_d] = {base_i, 3'(b)};
          fill_d          = fill_d + kbr_pkg::FillW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slots_q <= slots_d;
  end

  assign slots_o = slots_q;
  assign full_o  = (fill_q == kbr_pkg::FillW'(kbr_pkg::KeySlots));

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= kbr_pkg::FillW'(kbr_pkg::KeySlots))
    else $error("slot fill beyond six");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_i |=> (fill_q == '0) && (slots_q == '0))
    else $error("scanner not emptied by clear");

endmodule

>>> rtl/keyboard_report_builder_6kro.sv
// Boot keyboard report builder, six-key rollover. A key event is handled in
// steps: map update at the transfer edge, the byte scanner walking the key
// map, then a compare that sends the report to the output register if it
// changed; rollover ends the walk at byte zero. A new event is taken only in
// idle, once the last one is through; output stalls hold it back; an unknown code starts no walk.
// Reset (rst_ni low, async) clears the map, count, modifiers, last report and handshakes.
module keyboard_report_builder_6kro (
  input  logic        clk_i,
  input  logic        rst_ni,
  // event stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [7:0] usage, [15:8] modifier_mask
  input  logic [2:0]  s_axis_tuser,  // [2:0] req_type
  // report stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata   // [7:0] modifiers, [15:8] key_slot_0 .. [55:48] key_slot_5
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e                     state_q, state_d;
  logic [kbr_pkg::IdxW-1:0]   idx_q, idx_d;
  logic [55:0]                last_q, last_d;
  logic                       m_valid_q, m_valid_d;
  logic [55:0]                m_data_q, m_data_d;

  kbr_pkg::event_t            evt;
  kbr_pkg::slots_t            scan_slots, rpt_slots;
  logic [7:0]                 rd_byte, mods;
  logic [8:0]                 count;
  logic                       scan_full, rollover, in_xfer, valid_req;
  logic                       out_free, load;
  logic [55:0]                report;

  assign in_xfer   = s_axis_tvalid & s_axis_tready;
  assign valid_req = (s_axis_tuser == kbr_pkg::REQ_PRESS)   ||
                     (s_axis_tuser == kbr_pkg::REQ_RELEASE) ||
                     (s_axis_tuser == kbr_pkg::REQ_MOD_SET) ||
                     (s_axis_tuser == kbr_pkg::REQ_MOD_CLR) ||
                     (s_axis_tuser == kbr_pkg::REQ_RESET);

  assign evt.valid = in_xfer;
  assign evt.req   = s_axis_tuser;
  assign evt.usage = s_axis_tdata[7:0];
  assign evt.mask  = s_axis_tdata[15:8];

  kbr_keymap u_keymap (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .event_i   (evt),
    .rd_idx_i  (idx_q),
    .rd_byte_o (rd_byte),
    .count_o   (count),
    .mods_o    (mods)
  );

  kbr_scanner u_scanner (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clear_i  (in_xfer),
    .step_i   (state_q == ST_SCAN),
    .base_i   (idx_q),
    .byte_i   (rd_byte),
    .slots_o  (scan_slots),
    .full_o   (scan_full)
  );

  // more than six keys down: every slot reports rollover
  assign rollover = (count > 9'(kbr_pkg::KeySlots));

  always_comb begin
    for (int k = 0; k < kbr_pkg::KeySlots; k++) begin
      rpt_slots[k] = rollover ? kbr_pkg::RolloverCode : scan_slots[k];
    end
  end

  assign report   = {rpt_slots, mods};
  assign out_free = ~m_valid_q | m_axis_tready;
  assign load     = (state_q == ST_DONE) && out_free && (report != last_q);

  // sequencer: apply on transfer, walk map bytes, compare and send
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    last_d    = last_q;
    m_valid_d = m_valid_q & ~m_axis_tready;
    m_data_d  = m_data_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer && valid_req) begin
          state_d = ST_SCAN;
          idx_d   = '0;
        end
      end
      ST_SCAN: begin
        // stop on rollover, six slots filled, or last byte walked
        if (rollover || scan_full || (idx_q == kbr_pkg::IdxW'(kbr_pkg::MapBytes - 1))) begin
          state_d = ST_DONE;
        end else begin
          idx_d = idx_q + kbr_pkg::IdxW'(1);
        end
      end
      ST_DONE: begin
        if (report == last_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          last_d    = report;
          m_valid_d = 1'b1;
          m_data_d  = report;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      last_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      last_q    <= last_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // a sent report becomes the last-sent copy
  a_load_tracks_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> m_axis_tvalid && (m_axis_tdata == last_q))
    else $error("sent report differs from last-sent copy");

  // a known request starts the walk at byte zero
  a_scan_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && valid_req) |=> (state_q == ST_SCAN) && (idx_q == '0))
    else $error("scan did not start at byte zero");

  // unknown request codes are dropped without a report
  a_unknown_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && !valid_req) |=> (state_q == ST_IDLE))
    else $error("unknown request left idle");

endmodule
